@@ rtl/tes_pkg.sv @@
// Package for the tone effect sequencer: types, ROM contents and timer constants.
`timescale 1ns / 1ps

package tes_pkg;

   // Field widths
   localparam int HZ_W       = 15;
   localparam int DIVISOR_W  = 16;
   localparam int EFFECT_W   = 3;
   localparam int ENTRY_W    = 10;

   // Effect ROM geometry; the position can reach ROM_DEPTH itself
   localparam int ROM_DEPTH  = 64;
   localparam int ROM_POS_W  = $clog2(ROM_DEPTH + 1);
   localparam int LIST_LEN   = 56;
   localparam int LIST_IDX_W = $clog2(LIST_LEN);

   // Timer input clock and divider geometry
   localparam int PIT_W      = 21;
   localparam logic [PIT_W-1:0] PIT_CLOCK = PIT_W'(1193180);
   localparam int CNT_W      = $clog2(PIT_W);

   // Operation codes
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   // Number of defined effects: shoot, hit, collision, explosion, bonus, squeal
   localparam int NUM_EFFECTS = 6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   // Effect frequency lists, each closed by a zero entry
   localparam logic [ENTRY_W-1:0] EFFECT_LIST [LIST_LEN] = '{
      // shoot
      10'd80,  10'd150, 10'd200, 10'd180, 10'd150, 10'd110, 10'd85,  10'd60,  10'd0,
      // hit
      10'd80,  10'd150, 10'd800, 10'd400, 10'd0,
      // collision
      10'd60,  10'd100, 10'd80,  10'd55,  10'd0,
      // explosion
      10'd120, 10'd340, 10'd200, 10'd90,  10'd400, 10'd180, 10'd60,  10'd300,
      10'd220, 10'd100, 10'd360, 10'd140, 10'd80,  10'd260, 10'd0,
      // bonus
      10'd80,  10'd130, 10'd100, 10'd160, 10'd140, 10'd200, 10'd180, 10'd280,
      10'd240, 10'd370, 10'd320, 10'd550, 10'd0,
      // squeal
      10'd650, 10'd700, 10'd700, 10'd700, 10'd700, 10'd700, 10'd710, 10'd720,
      10'd0
   };

   // Head of each effect list
   localparam logic [ROM_POS_W-1:0] EFFECT_START [NUM_EFFECTS] = '{
      ROM_POS_W'(0),  ROM_POS_W'(9),  ROM_POS_W'(14),
      ROM_POS_W'(19), ROM_POS_W'(34), ROM_POS_W'(47)
   };

   // ROM read; entries past the lists, and positions past the ROM, read as zero
   function automatic logic [ENTRY_W-1:0] rom_read(input logic [ROM_POS_W-1:0] pos);
      logic [ENTRY_W-1:0] entry;
      entry = '0;
      if (int'(pos) < LIST_LEN) begin
         entry = EFFECT_LIST[pos[LIST_IDX_W-1:0]];
      end
      return entry;
   endfunction

endpackage

@@ rtl/tone_effect_sequencer_top.sv @@
// Tone effect sequencer: effect list stepping and bit-serial timer divisor unit.
`timescale 1ns / 1ps
//
// Usage:
//   The req_ channel carries one item per transfer: a start (req_operation = 1)
//   selects an effect list by req_effect_id, a tick (req_operation = 0) steps
//   the active list or falls back to req_engine_hz. Starts give no result;
//   every tick gives exactly one rsp_ transfer with divisor, load and gate.
//   A tick whose frequency changed to a nonzero value runs the shared restoring
//   divider, one quotient bit per cycle over 21 bits, and then registers its
//   result in the finish step; any other tick goes straight to that step.
//   A start completes in its transfer cycle and the next item is taken at once.
//   req_stall is high while a tick is in progress, so no new item is taken
//   before the last tick has registered its result.
//   The result register parts the channels: a new item is accepted while an
//   earlier result waits under rsp_stall; a finished tick waits in its last
//   step until that register is free.
//   Reset (synchronous, active high) stops any effect, clears the playing
//   frequency and drops rsp_valid.
module tone_effect_sequencer_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_operation,
   input  logic [tes_pkg::EFFECT_W-1:0] req_effect_id,
   input  logic [tes_pkg::HZ_W-1:0]     req_engine_hz,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [tes_pkg::DIVISOR_W-1:0] rsp_divisor,
   output logic                        rsp_load_divisor,
   output logic                        rsp_speaker_on
);
   import tes_pkg::*;

   // Control state
   state_type               state_ff, state_in;
   logic                    active_ff, active_in;
   logic [ROM_POS_W-1:0]    pos_ff, pos_in;
   logic [HZ_W-1:0]         playing_ff, playing_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Datapath registers
   logic [HZ_W-1:0]         freq_ff, freq_in;
   logic                    need_div_ff, need_div_in;
   logic                    spk_ff, spk_in;
   logic [HZ_W-1:0]         rem_ff, rem_in;
   logic [PIT_W-1:0]        quot_ff, quot_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [DIVISOR_W-1:0]    divisor_ff, divisor_in;
   logic                    load_ff, load_in;
   logic                    speaker_ff, speaker_in;

   logic                    accept;
   logic                    is_tick;
   logic                    rsp_free;
   logic [ENTRY_W-1:0]      entry;
   logic [HZ_W-1:0]         tick_hz;
   logic [HZ_W:0]           trial;
   logic                    trial_ge;
   logic [DIVISOR_W-1:0]    sat_quot;

   assign accept   = req_valid && !req_stall;
   assign is_tick  = (req_operation == OP_TICK);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Frequency for this tick: nonzero list entry while an effect plays, else engine
   assign entry   = rom_read(pos_ff);
   assign tick_hz = (active_ff && (entry != '0)) ? HZ_W'(entry) : req_engine_hz;

   // Shared restoring divide step
   assign trial    = {rem_ff, PIT_CLOCK[count_ff]};
   assign trial_ge = (trial >= {1'b0, freq_ff});
   assign sat_quot = (quot_ff[PIT_W-1:DIVISOR_W] != '0) ? '1 : quot_ff[DIVISOR_W-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && is_tick) begin
               if ((tick_hz != '0) && (tick_hz != playing_ff)) begin
                  state_in = ST_DIVIDE;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_DIVIDE: begin
            if (count_ff == '0) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs
   always_comb begin
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_DIVIDE: req_stall = 1'b1;
         ST_FINISH: req_stall = 1'b1;
         default:   req_stall = 1'b1;
      endcase
   end

   // Effect stepping and playing frequency
   always_comb begin
      active_in   = active_ff;
      pos_in      = pos_ff;
      playing_in  = playing_ff;
      freq_in     = freq_ff;
      need_div_in = need_div_ff;
      spk_in      = spk_ff;
      if (accept) begin
         if (!is_tick) begin
            if (int'(req_effect_id) < NUM_EFFECTS) begin
               active_in = 1'b1;
               pos_in    = EFFECT_START[req_effect_id];
            end
         end else begin
            if (active_ff) begin
               if (int'(pos_ff) < ROM_DEPTH) begin
                  pos_in = pos_ff + ROM_POS_W'(1);
               end
               if (entry == '0) begin
                  active_in = 1'b0;
                  pos_in    = '0;
               end
            end
            freq_in     = tick_hz;
            spk_in      = (tick_hz != '0);
            need_div_in = (tick_hz != '0) && (tick_hz != playing_ff);
            playing_in  = tick_hz;
         end
      end
   end

   // Divider iteration
   always_comb begin
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      count_in = count_ff;
      if (accept && is_tick) begin
         rem_in   = '0;
         quot_in  = '0;
         count_in = CNT_W'(PIT_W - 1);
      end else if (state_ff == ST_DIVIDE) begin
         rem_in   = trial_ge ? HZ_W'(trial - {1'b0, freq_ff}) : trial[HZ_W-1:0];
         quot_in  = {quot_ff[PIT_W-2:0], trial_ge};
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      divisor_in   = divisor_ff;
      load_in      = load_ff;
      speaker_in   = speaker_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_FINISH) && rsp_free) begin
         rsp_valid_in = 1'b1;
         divisor_in   = need_div_ff ? sat_quot : '0;
         load_in      = need_div_ff;
         speaker_in   = spk_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         pos_ff       <= '0;
         playing_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         pos_ff       <= pos_in;
         playing_ff   <= playing_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      freq_ff     <= freq_in;
      need_div_ff <= need_div_in;
      spk_ff      <= spk_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      count_ff    <= count_in;
      divisor_ff  <= divisor_in;
      load_ff     <= load_in;
      speaker_ff  <= speaker_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_divisor      = divisor_ff;
   assign rsp_load_divisor = load_ff;
   assign rsp_speaker_on   = speaker_ff;

endmodule

@@ tb/tone_effect_sequencer_top_test.sv @@
// Testbench for the tone effect sequencer: random starts and ticks checked against a tone predictor.
`timescale 1ns / 1ps

module tone_effect_sequencer_top_test;

   // Timer input clock and effect ROM geometry as seen by the predictor
   localparam int unsigned PIT_HZ       = 1193180;
   localparam int unsigned LIST_ENTRIES = 56;
   localparam int unsigned ROM_ENTRIES  = 64;
   localparam int unsigned RANDOM_ITEMS = 700;
   localparam int          LONG_HOLD    = 300;
   localparam int          DRAIN_CYCLES = 40;

   // One result transfer
   typedef struct packed {
      logic [tes_pkg::DIVISOR_W-1:0] divisor;
      logic                          load;
      logic                          speaker;
   } tone_type;

   // Tone predictor and result scoreboard
   class tone_checker;
      tone_type    expected_tones[$];
      int unsigned mismatches = 0;
      bit          effect_on  = 1'b0;
      int unsigned list_pos   = 0;
      int unsigned playing_hz = 0;
      int unsigned effect_lists[LIST_ENTRIES] = '{
         80, 150, 200, 180, 150, 110, 85, 60, 0,
         80, 150, 800, 400, 0,
         60, 100, 80, 55, 0,
         120, 340, 200, 90, 400, 180, 60, 300, 220, 100, 360, 140, 80, 260, 0,
         80, 130, 100, 160, 140, 200, 180, 280, 240, 370, 320, 550, 0,
         650, 700, 700, 700, 700, 700, 710, 720, 0
      };
      int unsigned effect_heads[tes_pkg::NUM_EFFECTS] = '{0, 9, 14, 19, 34, 47};

      // Advance the sequencer by one accepted input transfer
      function void note_transfer(logic op, logic [tes_pkg::EFFECT_W-1:0] id,
                                  logic [tes_pkg::HZ_W-1:0] hz);
         tone_type    tone;
         int unsigned freq;
         int unsigned quotient;
         if (op == tes_pkg::OP_START) begin
            // unknown ids leave everything as it was
            if (id < tes_pkg::NUM_EFFECTS) begin
               list_pos  = effect_heads[id];
               effect_on = 1'b1;
            end
            return;
         end
         freq = hz;
         if (effect_on) begin
            freq = (list_pos < LIST_ENTRIES) ? effect_lists[list_pos] : 0;
            if (list_pos < ROM_ENTRIES) list_pos++;
            // zero entry closes the effect, engine tone takes over
            if (freq == 0) begin
               effect_on = 1'b0;
               list_pos  = 0;
               freq      = hz;
            end
         end
         tone = '0;
         if (freq != 0) begin
            if (freq != playing_hz) begin
               quotient     = PIT_HZ / freq;
               tone.divisor = (quotient > 65535) ? 16'hFFFF : 16'(quotient);
               tone.load    = 1'b1;
               playing_hz   = freq;
            end
            tone.speaker = 1'b1;
         end else begin
            playing_hz = 0;
         end
         expected_tones.push_back(tone);
      endfunction

      // Compare one result transfer with the oldest expected tone
      function void check_tone(logic [tes_pkg::DIVISOR_W-1:0] divisor, logic load,
                               logic speaker);
         tone_type want;
         if (expected_tones.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result: divisor %0d load %0b speaker %0b",
                     $time, divisor, load, speaker);
            return;
         end
         want = expected_tones.pop_front();
         if (divisor !== want.divisor) begin
            mismatches++;
            $display("%0t: divisor expected %0d actual %0d", $time, want.divisor, divisor);
         end
         if (load !== want.load) begin
            mismatches++;
            $display("%0t: load_divisor expected %0b actual %0b", $time, want.load, load);
         end
         if (speaker !== want.speaker) begin
            mismatches++;
            $display("%0t: speaker_on expected %0b actual %0b", $time, want.speaker, speaker);
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_operation = tes_pkg::OP_TICK;
   logic [tes_pkg::EFFECT_W-1:0]  req_effect_id = '0;
   logic [tes_pkg::HZ_W-1:0]      req_engine_hz = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [tes_pkg::DIVISOR_W-1:0] rsp_divisor;
   logic                          rsp_load_divisor;
   logic                          rsp_speaker_on;

   tone_checker                   tones = new();
   bit                            no_gap_stretch = 1'b0;
   int                            hold_requested = 0;
   int                            hold_served = 0;
   logic [tes_pkg::HZ_W-1:0]      last_hz = '0;

   tone_effect_sequencer_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_effect_id    (req_effect_id),
      .req_engine_hz    (req_engine_hz),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_divisor      (rsp_divisor),
      .rsp_load_divisor (rsp_load_divisor),
      .rsp_speaker_on   (rsp_speaker_on)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Sender idle gap: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gap_stretch) return 0;
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Engine frequency: repeats, silence, 1 to 30 Hz, audible and full field range
   function automatic logic [tes_pkg::HZ_W-1:0] pick_engine();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return last_hz;
      if (r < 40) last_hz = '0;
      else if (r < 60) last_hz = 15'($urandom_range(1, 30));
      else if (r < 80) last_hz = 15'($urandom_range(31, 2000));
      else last_hz = 15'($urandom);
      return last_hz;
   endfunction

   // Offer one item and hold it until the transfer
   task automatic send_item(input logic op, input logic [tes_pkg::EFFECT_W-1:0] id,
                            input logic [tes_pkg::HZ_W-1:0] hz);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_effect_id <= id;
      req_engine_hz <= hz;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      tones.note_transfer(op, id, hz);
   endtask

   // Result side: check every transfer, stall in random runs and one long hold-off
   initial begin
      int  run_left;
      int  hold_left;
      bit  stalling;
      int  r;
      run_left  = 0;
      hold_left = 0;
      stalling  = 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            tones.check_tone(rsp_divisor, rsp_load_divisor, rsp_speaker_on);
         end
         if (hold_left > 0) begin
            hold_left--;
         end else if (hold_served < hold_requested) begin
            hold_served++;
            hold_left = LONG_HOLD;
         end else if (run_left > 0) begin
            run_left--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
               stalling = 1'b0;
               run_left = $urandom_range(1, 4);
            end else if (r < 85) begin
               stalling = 1'b1;
               run_left = $urandom_range(1, 3);
            end else if (r < 93) begin
               stalling = 1'b0;
               run_left = $urandom_range(50, 200);
            end else begin
               stalling = 1'b1;
               run_left = $urandom_range(20, 60);
            end
         end
         rsp_stall <= (hold_left > 0) || stalling;
      end
   end

   // Stimulus: reset, directed items, random effect sequences and noise, then drain
   initial begin
      int unsigned effect_items;
      int          n;
      int          i;
      logic [tes_pkg::EFFECT_W-1:0] fx;
      logic        op;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // silence, saturation, repeats and the extremes of the engine field
      send_item(tes_pkg::OP_TICK, 3'd7, 15'd0);
      send_item(tes_pkg::OP_TICK, 3'd0, 15'd20000);
      send_item(tes_pkg::OP_TICK, 3'd5, 15'd20000);
      send_item(tes_pkg::OP_TICK, 3'd2, 15'd1);
      send_item(tes_pkg::OP_TICK, 3'd1, 15'd18);
      send_item(tes_pkg::OP_TICK, 3'd6, 15'd19);
      send_item(tes_pkg::OP_TICK, 3'd3, 15'h7FFF);
      send_item(tes_pkg::OP_TICK, 3'd4, 15'd0);
      // unknown effect ids are ignored
      send_item(tes_pkg::OP_START, 3'd7, 15'h7FFF);
      send_item(tes_pkg::OP_START, 3'd6, 15'd0);
      send_item(tes_pkg::OP_TICK, 3'd0, 15'd440);
      // collision run to its zero entry, engine takes over
      send_item(tes_pkg::OP_START, 3'd2, 15'd0);
      for (i = 0; i < 5; i++) send_item(tes_pkg::OP_TICK, 3'd0, 15'd300);
      // restart while another effect plays
      send_item(tes_pkg::OP_START, 3'd1, 15'd0);
      send_item(tes_pkg::OP_TICK, 3'd0, 15'd300);
      send_item(tes_pkg::OP_START, 3'd5, 15'd0);
      send_item(tes_pkg::OP_TICK, 3'd0, 15'd300);
      send_item(tes_pkg::OP_START, 3'd3, 15'd0);
      send_item(tes_pkg::OP_START, 3'd4, 15'd0);
      send_item(tes_pkg::OP_TICK, 3'd0, 15'd0);
      send_item(tes_pkg::OP_START, 3'd0, 15'd0);
      send_item(tes_pkg::OP_TICK, 3'd0, 15'd80);

      // random part
      effect_items = 0;
      while (effect_items < RANDOM_ITEMS) begin
         no_gap_stretch = ($urandom_range(0, 4) == 0);
         if (effect_items >= 150 && hold_requested == 0) hold_requested = 1;
         if ($urandom_range(0, 99) < 65) begin
            // start an effect and tick through part or all of it
            fx = 3'($urandom_range(0, tes_pkg::NUM_EFFECTS - 1));
            send_item(tes_pkg::OP_START, fx, 15'($urandom));
            effect_items++;
            n = $urandom_range(1, 18);
            for (i = 0; i < n; i++) begin
               if ($urandom_range(0, 29) == 0) begin
                  fx = 3'($urandom);
                  send_item(tes_pkg::OP_START, fx, 15'($urandom));
                  if (fx < tes_pkg::NUM_EFFECTS) effect_items++;
               end
               send_item(tes_pkg::OP_TICK, 3'($urandom), pick_engine());
               effect_items++;
            end
         end else begin
            // loose mix of starts and ticks
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) begin
               op = ($urandom_range(0, 3) == 0) ? tes_pkg::OP_START : tes_pkg::OP_TICK;
               fx = 3'($urandom);
               send_item(op, fx, pick_engine());
               if (op == tes_pkg::OP_TICK || fx < tes_pkg::NUM_EFFECTS) effect_items++;
            end
         end
      end
      req_valid <= 1'b0;

      // drain and let any stray result show up
      while (tones.expected_tones.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tones.mismatches == 0 && tones.expected_tones.size() == 0) begin
         $display("tone_effect_sequencer_top test passed");
      end else begin
         $display("tone_effect_sequencer_top test failed");
      end
      $finish;
   end

   // Timeout
   initial begin
      #10_000_000;
      $display("tone_effect_sequencer_top test failed");
      $finish;
   end

endmodule
